// ----- sv/sfwm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scrolling frame window mapper package
// Shared widths, codes, control word type and the sequencer program.
// ----------------------------------------------------------------------------
package sfwm_pkg;

    // field widths
    localparam int COL_W  = 8;
    localparam int ROW_W  = 9;
    localparam int MOD_W  = ROW_W + 1;   // modulus, up to 512
    localparam int ARG_W  = ROW_W + 2;   // operand of the remainder unit
    localparam int OFF_W  = 17;
    localparam int DIR_W  = 2;
    localparam int PC_W   = 4;
    localparam int CNT_W  = 4;

    // register reset values
    localparam logic [ROW_W-1:0] TOTAL_RESET   = 9'd320;
    localparam logic [ROW_W-1:0] VISIBLE_RESET = 9'd240;

    // configuration register indexes
    localparam logic CFG_TOTAL   = 1'b0;
    localparam logic CFG_VISIBLE = 1'b1;

    // scroll direction codes
    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

    // sequencer phases
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_MOD
    } t_state;

    // micro-operations
    typedef enum logic [1:0] {
        OP_MOD,
        OP_JUMP,
        OP_EMIT
    } t_op;

    // operand select for the remainder unit
    typedef enum logic [2:0] {
        X_WB,
        X_VIS,
        X_COMB,
        X_ROW1,
        X_ROW2,
        X_SS,
        X_STEP
    } t_xsel;

    // destination of a remainder
    typedef enum logic [2:0] {
        D_T,
        D_U,
        D_WB,
        D_ROW1,
        D_ROW2,
        D_SS
    } t_dst;

    // jump conditions
    typedef enum logic {
        C_NO_BASE,
        C_NO_SCROLL
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_xsel            xsel;
        t_dst             dst;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    localparam logic [PC_W-1:0] PC_ROWS = 4'd4;
    localparam logic [PC_W-1:0] PC_EMIT = 4'd10;

    // control store: one word per step
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_EMIT, xsel: X_WB, dst: D_T, cond: C_NO_BASE, target: '0};
        case (pc)
            4'd0:  w = '{op: OP_JUMP, xsel: X_WB,   dst: D_T,    cond: C_NO_BASE,
                        target: PC_ROWS};
            4'd1:  w = '{op: OP_MOD,  xsel: X_WB,   dst: D_T,    cond: C_NO_BASE,
                        target: '0};
            4'd2:  w = '{op: OP_MOD,  xsel: X_VIS,  dst: D_U,    cond: C_NO_BASE,
                        target: '0};
            4'd3:  w = '{op: OP_MOD,  xsel: X_COMB, dst: D_WB,   cond: C_NO_BASE,
                        target: '0};
            4'd4:  w = '{op: OP_MOD,  xsel: X_ROW1, dst: D_ROW1, cond: C_NO_BASE,
                        target: '0};
            4'd5:  w = '{op: OP_MOD,  xsel: X_ROW2, dst: D_ROW2, cond: C_NO_BASE,
                        target: '0};
            4'd6:  w = '{op: OP_JUMP, xsel: X_WB,   dst: D_T,    cond: C_NO_SCROLL,
                        target: PC_EMIT};
            4'd7:  w = '{op: OP_MOD,  xsel: X_SS,   dst: D_T,    cond: C_NO_BASE,
                        target: '0};
            4'd8:  w = '{op: OP_MOD,  xsel: X_STEP, dst: D_U,    cond: C_NO_BASE,
                        target: '0};
            4'd9:  w = '{op: OP_MOD,  xsel: X_COMB, dst: D_SS,   cond: C_NO_BASE,
                        target: '0};
            default: w = '{op: OP_EMIT, xsel: X_WB, dst: D_T,    cond: C_NO_BASE,
                        target: '0};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- sv/scrolling_frame_window_mapper.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scrolling frame window mapper
// Maps a flushed screen rectangle into a circular frame memory and issues
// one or two frame windows, with scroll start updates.
// ----------------------------------------------------------------------------
// One rectangle is handled at a time. A short program in a control store
// steps a datapath whose only arithmetic unit is a bit-serial remainder unit
// (one quotient bit per cycle, with a load step before each reduction).
// A rectangle runs the fewest reductions with no base or scroll change and
// the most when both the write base and the scroll start move; a rectangle that
// wraps past the last frame row adds one output transaction. The result
// register lets the next rectangle be taken and worked on while a result is
// still waiting; the final step waits only if the result register is full.
// Configuration writes take effect at once and should be made while idle.
module scrolling_frame_window_mapper (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_addr,
    input  wire logic [sfwm_pkg::ROW_W-1:0]    i_cfg_data,
    // rectangle channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [sfwm_pkg::COL_W-1:0]    i_area_left,
    input  wire logic [sfwm_pkg::COL_W-1:0]    i_area_right,
    input  wire logic [sfwm_pkg::ROW_W-1:0]    i_area_top,
    input  wire logic [sfwm_pkg::ROW_W-1:0]    i_area_bottom,
    input  wire logic [sfwm_pkg::DIR_W-1:0]    i_scroll_dir,
    // window channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [sfwm_pkg::COL_W-1:0]         o_win_col,
    output logic [sfwm_pkg::ROW_W-1:0]         o_win_row,
    output logic [sfwm_pkg::COL_W-1:0]         o_win_width,
    output logic [sfwm_pkg::ROW_W-1:0]         o_win_height,
    output logic [sfwm_pkg::OFF_W-1:0]         o_pixel_offset,
    output logic                               o_scroll_update,
    output logic [sfwm_pkg::ROW_W-1:0]         o_scroll_address,
    output logic                               o_scroll_done,
    output logic                               o_last_window
);

    localparam int COL_W = sfwm_pkg::COL_W;
    localparam int ROW_W = sfwm_pkg::ROW_W;
    localparam int MOD_W = sfwm_pkg::MOD_W;
    localparam int ARG_W = sfwm_pkg::ARG_W;
    localparam int OFF_W = sfwm_pkg::OFF_W;
    localparam int DIR_W = sfwm_pkg::DIR_W;
    localparam int PC_W  = sfwm_pkg::PC_W;
    localparam int CNT_W = sfwm_pkg::CNT_W;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ARG_W - 1);

    // configuration registers
    logic [ROW_W-1:0] r_total;
    logic [ROW_W-1:0] r_visible;

    // captured rectangle
    logic [COL_W-1:0] r_left;
    logic [COL_W-1:0] r_right;
    logic [ROW_W-1:0] r_top;
    logic [ROW_W-1:0] r_bottom;
    logic [DIR_W-1:0] r_dir;

    // datapath state and scratch
    logic [ROW_W-1:0] r_wb;
    logic [ROW_W-1:0] r_ss;
    logic [ROW_W-1:0] r_t;
    logic [ROW_W-1:0] r_u;
    logic [ROW_W-1:0] r_row1;
    logic [ROW_W-1:0] r_row2;

    // remainder unit
    logic [ARG_W-1:0] r_mx;
    logic [ROW_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;

    // sequencer
    sfwm_pkg::t_state r_state;
    sfwm_pkg::t_state n_state;
    logic [PC_W-1:0]  r_pc;
    sfwm_pkg::t_uword uw;

    // output register and pending second window
    logic             r_out_valid;
    logic             r_sec_pend;
    logic [ROW_W-1:0] r_sec_h;
    logic [OFF_W-1:0] r_sec_off;

    // control strobes
    logic in_fire;
    logic mod_load;
    logic mod_step;
    logic mod_last;
    logic emit_fire;
    logic jump_taken;
    logic out_fire;

    // decoded rectangle conditions
    logic [MOD_W-1:0] m10;
    logic             is_down;
    logic             is_up;
    logic [MOD_W-1:0] bottom1;
    logic             bottom_last;
    logic             top_zero;
    logic             base_upd;
    logic             scr_upd;
    logic             dbl;
    logic [ROW_W-1:0] height;
    logic [MOD_W-1:0] step;
    logic [ARG_W-1:0] comb_val;
    logic [ARG_W-1:0] mod_arg;
    logic [MOD_W-1:0] trial;
    logic [ROW_W-1:0] rem_next;

    // emit datapath
    logic             split;
    logic [MOD_W-1:0] h1;
    logic [COL_W-1:0] width;
    logic [COL_W+MOD_W-1:0] prod;

    assign uw = sfwm_pkg::ucode(r_pc);

    // modulus: zero total lines acts as 512
    assign m10 = (r_total == '0) ? MOD_W'(512) : {1'b0, r_total};

    // rectangle decode
    assign is_down     = (r_dir == sfwm_pkg::DIR_DOWN);
    assign is_up       = (r_dir == sfwm_pkg::DIR_UP);
    assign bottom1     = {1'b0, r_bottom} + MOD_W'(1);
    assign bottom_last = (bottom1 == {1'b0, r_visible});
    assign top_zero    = (r_top == '0);
    assign base_upd    = (is_down && bottom_last) || (is_up && top_zero);
    assign scr_upd     = (is_down && (bottom1 < {1'b0, r_visible})) ||
                         (is_up && !top_zero);
    assign dbl         = is_down ? top_zero : bottom_last;
    assign height      = r_bottom - r_top + ROW_W'(1);
    assign step        = dbl ? {height, 1'b0} : {1'b0, height};

    // add or subtract of two reduced values, below twice the modulus
    assign comb_val = is_down ? ({2'b00, r_t} + {1'b0, m10} - {2'b00, r_u})
                              : ({2'b00, r_t} + {2'b00, r_u});

    // remainder unit operand select
    always_comb begin
        case (uw.xsel)
            sfwm_pkg::X_WB:   mod_arg = {2'b00, r_wb};
            sfwm_pkg::X_VIS:  mod_arg = {2'b00, r_visible};
            sfwm_pkg::X_COMB: mod_arg = comb_val;
            sfwm_pkg::X_ROW1: mod_arg = {2'b00, r_top} + {2'b00, r_wb};
            sfwm_pkg::X_ROW2: mod_arg = {2'b00, r_bottom} + {2'b00, r_wb};
            sfwm_pkg::X_SS:   mod_arg = {2'b00, r_ss};
            sfwm_pkg::X_STEP: mod_arg = {1'b0, step};
            default:          mod_arg = '0;
        endcase
    end

    // one restoring remainder step
    assign trial    = {r_rem, r_mx[ARG_W-1]};
    assign rem_next = (trial >= m10) ? ROW_W'(trial - m10) : trial[ROW_W-1:0];
    assign mod_last = (r_cnt == CNT_LAST);

    // window arithmetic
    assign split = (r_row2 < r_row1);
    assign h1    = m10 - {1'b0, r_row1};
    assign width = r_right - r_left + COL_W'(1);
    assign prod  = width * h1;

    assign jump_taken = (uw.cond == sfwm_pkg::C_NO_BASE) ? !base_upd : !scr_upd;
    assign out_fire   = r_out_valid && i_out_ready;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sfwm_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = sfwm_pkg::ST_RUN;
            end
            sfwm_pkg::ST_RUN: begin
                case (uw.op)
                    sfwm_pkg::OP_MOD:  n_state = sfwm_pkg::ST_MOD;
                    sfwm_pkg::OP_JUMP: n_state = sfwm_pkg::ST_RUN;
                    sfwm_pkg::OP_EMIT: begin
                        if (!r_out_valid) n_state = sfwm_pkg::ST_IDLE;
                    end
                    default:           n_state = sfwm_pkg::ST_IDLE;
                endcase
            end
            sfwm_pkg::ST_MOD: begin
                if (mod_last) n_state = sfwm_pkg::ST_RUN;
            end
            default: n_state = sfwm_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        mod_load   = 1'b0;
        mod_step   = 1'b0;
        emit_fire  = 1'b0;
        case (r_state)
            sfwm_pkg::ST_IDLE: o_in_ready = 1'b1;
            sfwm_pkg::ST_RUN: begin
                mod_load  = (uw.op == sfwm_pkg::OP_MOD);
                emit_fire = (uw.op == sfwm_pkg::OP_EMIT) && !r_out_valid;
            end
            sfwm_pkg::ST_MOD:  mod_step = 1'b1;
            default: ;
        endcase
    end

    assign in_fire = i_in_valid && o_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= sfwm_pkg::TOTAL_RESET;
            r_visible <= sfwm_pkg::VISIBLE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == sfwm_pkg::CFG_TOTAL) r_total <= i_cfg_data;
            else                                   r_visible <= i_cfg_data;
        end
    end

    // sequencer state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfwm_pkg::ST_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_pc <= '0;
            end else if (r_state == sfwm_pkg::ST_RUN && uw.op == sfwm_pkg::OP_JUMP) begin
                r_pc <= jump_taken ? uw.target : r_pc + PC_W'(1);
            end else if (mod_step && mod_last) begin
                r_pc <= r_pc + PC_W'(1);
            end
        end
    end

    // rectangle capture
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_left   <= i_area_left;
            r_right  <= i_area_right;
            r_top    <= i_area_top;
            r_bottom <= i_area_bottom;
            r_dir    <= i_scroll_dir;
        end
    end

    // remainder unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (mod_load) begin
            r_cnt <= '0;
        end else if (mod_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mod_load) begin
            r_mx  <= mod_arg;
            r_rem <= '0;
        end else if (mod_step) begin
            r_mx  <= {r_mx[ARG_W-2:0], 1'b0};
            r_rem <= rem_next;
        end
    end

    // write base and scroll start, updated by the program
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb <= '0;
            r_ss <= '0;
        end else if (mod_step && mod_last) begin
            if (uw.dst == sfwm_pkg::D_WB) r_wb <= rem_next;
            if (uw.dst == sfwm_pkg::D_SS) r_ss <= rem_next;
        end
    end

    // scratch registers
    always_ff @(posedge i_clk) begin
        if (mod_step && mod_last) begin
            case (uw.dst)
                sfwm_pkg::D_T:    r_t    <= rem_next;
                sfwm_pkg::D_U:    r_u    <= rem_next;
                sfwm_pkg::D_ROW1: r_row1 <= rem_next;
                sfwm_pkg::D_ROW2: r_row2 <= rem_next;
                default: ;
            endcase
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sec_pend  <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
            r_sec_pend  <= split;
        end else if (out_fire) begin
            if (r_sec_pend) r_sec_pend  <= 1'b0;
            else            r_out_valid <= 1'b0;
        end
    end

    // output payload: first window at emit, second after first transaction
    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            o_win_col        <= r_left;
            o_win_row        <= r_row1;
            o_win_width      <= width;
            o_win_height     <= split ? h1[ROW_W-1:0] : height;
            o_pixel_offset   <= '0;
            o_scroll_update  <= scr_upd;
            o_scroll_address <= scr_upd ? r_ss : '0;
            o_scroll_done    <= scr_upd && dbl;
            o_last_window    <= !split;
            r_sec_h          <= r_row2 + ROW_W'(1);
            r_sec_off        <= prod[OFF_W-1:0];
        end else if (out_fire && r_sec_pend) begin
            o_win_row        <= '0;
            o_win_height     <= r_sec_h;
            o_pixel_offset   <= r_sec_off;
            o_scroll_update  <= 1'b0;
            o_scroll_address <= '0;
            o_scroll_done    <= 1'b0;
            o_last_window    <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scrolling frame window mapper testbench
// Sends flushed rectangles under several frame memory settings and compares
// every frame window with a window mapping predictor kept in a scoreboard.
// Both handshakes idle and stall at random, and the receiver holds off for
// long stretches to fill the block.
// ----------------------------------------------------------------------------
module testbench;
    import sfwm_pkg::*;

    localparam int                 CLK_HALF        = 2;
    localparam int                 RESET_CYCLES    = 6;
    localparam int                 DRAIN_CYCLES    = 120;
    localparam int                 LONG_HOLD       = 400;
    localparam int                 RAND_PHASES     = 10;
    localparam int                 ITEMS_PER_PHASE = 165;
    localparam int                 HOLD_AT_ITEM    = 40;
    localparam logic [DIR_W-1:0]   DIR_SPARE       = 2'd3;
    localparam int unsigned        MAX_COLS_TB     = 240;

    // frame settings and idling level for each random phase; the second last phase draws its own settings
    localparam int unsigned PHASE_TOTAL [RAND_PHASES] =
        '{320, 511, 1, 0, 320, 100, 0, 255, 320, 320};
    localparam int unsigned PHASE_VISIBLE [RAND_PHASES] =
        '{240, 511, 1, 240, 0, 60, 0, 400, 240, 240};
    localparam int unsigned PHASE_GAP [RAND_PHASES] =
        '{20, 35, 0, 20, 50, 10, 0, 30, 25, 0};

    typedef struct packed {
        logic [COL_W-1:0] area_left;
        logic [COL_W-1:0] area_right;
        logic [ROW_W-1:0] area_top;
        logic [ROW_W-1:0] area_bottom;
        logic [DIR_W-1:0] scroll_dir;
    } t_rect;

    typedef struct packed {
        logic [COL_W-1:0] win_col;
        logic [ROW_W-1:0] win_row;
        logic [COL_W-1:0] win_width;
        logic [ROW_W-1:0] win_height;
        logic [OFF_W-1:0] pixel_offset;
        logic             scroll_update;
        logic [ROW_W-1:0] scroll_address;
        logic             scroll_done;
        logic             last_window;
    } t_window;

    // window mapping predictor and the windows still to come
    class window_map_scoreboard;
        int unsigned total_lines;
        int unsigned visible_lines;
        int unsigned write_base;
        int unsigned scroll_start;
        t_window     pending_windows[$];
        int          errors;

        function new();
            total_lines   = TOTAL_RESET;
            visible_lines = VISIBLE_RESET;
            write_base    = 0;
            scroll_start  = 0;
            errors        = 0;
        endfunction

        function void set_register(logic idx, logic [ROW_W-1:0] val);
            if (idx == CFG_TOTAL) begin
                total_lines = val;
            end else begin
                visible_lines = val;
            end
        endfunction

        // work out the windows of one accepted rectangle
        function void map_rect(t_rect r);
            int unsigned m, top, bottom, lft, rgt;
            int unsigned row1, row2, width, height, step, h1, addr;
            bit          down, up, bottom_last, update, done;
            t_window     w;
            m           = (total_lines == 0) ? 512 : total_lines;
            top         = r.area_top;
            bottom      = r.area_bottom;
            lft         = r.area_left;
            rgt         = r.area_right;
            down        = (r.scroll_dir == DIR_DOWN);
            up          = (r.scroll_dir == DIR_UP);
            bottom_last = (bottom + 1 == visible_lines);
            update      = 1'b0;
            done        = 1'b0;
            addr        = 0;
            // write base moves on the opening rectangle of a scroll
            if (down && bottom_last) begin
                write_base = (write_base % m + m - visible_lines % m) % m;
            end else if (up && top == 0) begin
                write_base = (write_base % m + visible_lines % m) % m;
            end
            row1   = (top + write_base) % m;
            row2   = (bottom + write_base) % m;
            width  = (rgt + 257 - lft) % 256;
            height = (bottom + 513 - top) % 512;
            // scroll start follows the rows already drawn
            if (down) begin
                if (bottom + 1 < visible_lines) begin
                    step = height;
                    if (top == 0) begin
                        step = height * 2;
                        done = 1'b1;
                    end
                    scroll_start = (scroll_start % m + m - step % m) % m;
                    update       = 1'b1;
                    addr         = scroll_start;
                end
            end else if (up) begin
                if (top > 0) begin
                    step = height;
                    if (bottom_last) begin
                        step = height * 2;
                        done = 1'b1;
                    end
                    scroll_start = (scroll_start % m + step) % m;
                    update       = 1'b1;
                    addr         = scroll_start;
                end
            end
            w                = '0;
            w.win_col        = r.area_left;
            w.win_width      = COL_W'(width);
            w.win_row        = ROW_W'(row1);
            w.scroll_update  = update;
            w.scroll_address = ROW_W'(addr);
            w.scroll_done    = done;
            // a rectangle running past the last frame row splits in two
            if (row2 < row1) begin
                h1           = m - row1;
                w.win_height = ROW_W'(h1);
                pending_windows.push_back(w);
                w.win_row        = '0;
                w.win_height     = ROW_W'(row2 + 1);
                w.pixel_offset   = OFF_W'(width * h1);
                w.scroll_update  = 1'b0;
                w.scroll_address = '0;
                w.scroll_done    = 1'b0;
                w.last_window    = 1'b1;
                pending_windows.push_back(w);
            end else begin
                w.win_height  = ROW_W'(height);
                w.last_window = 1'b1;
                pending_windows.push_back(w);
            end
        endfunction

        function void field_check(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // compare one window transaction with the oldest expected window
        function void check_window(t_window got);
            t_window want;
            if (pending_windows.size() == 0) begin
                $error("window transaction with no rectangle outstanding");
                errors++;
                return;
            end
            want = pending_windows.pop_front();
            field_check("win_col",        want.win_col,        got.win_col);
            field_check("win_row",        want.win_row,        got.win_row);
            field_check("win_width",      want.win_width,      got.win_width);
            field_check("win_height",     want.win_height,     got.win_height);
            field_check("pixel_offset",   want.pixel_offset,   got.pixel_offset);
            field_check("scroll_update",  want.scroll_update,  got.scroll_update);
            field_check("scroll_address", want.scroll_address, got.scroll_address);
            field_check("scroll_done",    want.scroll_done,    got.scroll_done);
            field_check("last_window",    want.last_window,    got.last_window);
        endfunction
    endclass

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    logic             i_cfg_addr    = CFG_TOTAL;
    logic [ROW_W-1:0] i_cfg_data    = '0;
    logic             i_in_valid    = 1'b0;
    logic             o_in_ready;
    logic [COL_W-1:0] i_area_left   = '0;
    logic [COL_W-1:0] i_area_right  = '0;
    logic [ROW_W-1:0] i_area_top    = '0;
    logic [ROW_W-1:0] i_area_bottom = '0;
    logic [DIR_W-1:0] i_scroll_dir  = DIR_NONE;
    logic             o_out_valid;
    logic             i_out_ready   = 1'b0;
    logic [COL_W-1:0] o_win_col;
    logic [ROW_W-1:0] o_win_row;
    logic [COL_W-1:0] o_win_width;
    logic [ROW_W-1:0] o_win_height;
    logic [OFF_W-1:0] o_pixel_offset;
    logic             o_scroll_update;
    logic [ROW_W-1:0] o_scroll_address;
    logic             o_scroll_done;
    logic             o_last_window;

    window_map_scoreboard sb = new();

    int unsigned      gap_pct   = 0;
    bit               hold_req  = 1'b0;
    logic [DIR_W-1:0] seq_dir   = DIR_NONE;
    int unsigned      seq_left  = 0;
    bit               seq_first = 1'b0;

    scrolling_frame_window_mapper i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_area_left      (i_area_left),
        .i_area_right     (i_area_right),
        .i_area_top       (i_area_top),
        .i_area_bottom    (i_area_bottom),
        .i_scroll_dir     (i_scroll_dir),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_win_col        (o_win_col),
        .o_win_row        (o_win_row),
        .o_win_width      (o_win_width),
        .o_win_height     (o_win_height),
        .o_pixel_offset   (o_pixel_offset),
        .o_scroll_update  (o_scroll_update),
        .o_scroll_address (o_scroll_address),
        .o_scroll_done    (o_scroll_done),
        .o_last_window    (o_last_window)
    );

    // clock
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // transaction monitors on both channels
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sb.map_rect(t_rect'{i_area_left, i_area_right, i_area_top, i_area_bottom,
                                i_scroll_dir});
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_window(t_window'{o_win_col, o_win_row, o_win_width, o_win_height,
                                      o_pixel_offset, o_scroll_update, o_scroll_address,
                                      o_scroll_done, o_last_window});
        end
    end

    // window receiver: short random stalls, long hold-offs on request
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && gap_pct != 0 && $urandom_range(99) < gap_pct) begin
                stall_left = $urandom_range(6, 1);
            end
            if (stall_left != 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic t_rect rect(int unsigned l, int unsigned r, int unsigned t,
                                   int unsigned b, logic [DIR_W-1:0] d);
        rect = t_rect'{COL_W'(l), COL_W'(r), ROW_W'(t), ROW_W'(b), d};
    endfunction

    // random rectangle, mostly as part of a scroll sequence
    function automatic t_rect make_rect();
        t_rect       r;
        int unsigned lim, pick, lo;
        lim  = (sb.visible_lines == 0) ? 512 : sb.visible_lines;
        lo   = (lim > 1) ? 1 : 0;
        pick = $urandom_range(99);
        // noise over the whole field ranges
        if (pick < 12) begin
            return rect($urandom_range(255), $urandom_range(255), $urandom_range(511),
                        $urandom_range(511), DIR_W'($urandom_range(3)));
        end
        r.area_left  = COL_W'($urandom_range(MAX_COLS_TB - 1));
        r.area_right = COL_W'($urandom_range(MAX_COLS_TB - 1, r.area_left));
        // broken sequence: on-screen rows, any order, any direction
        if (pick < 20) begin
            r.area_top    = ROW_W'($urandom_range(lim - 1));
            r.area_bottom = ROW_W'($urandom_range(lim - 1));
            r.scroll_dir  = DIR_W'($urandom_range(3));
            return r;
        end
        if (seq_left == 0) begin
            case ($urandom_range(2))
                0:       seq_dir = DIR_NONE;
                1:       seq_dir = DIR_UP;
                default: seq_dir = DIR_DOWN;
            endcase
            seq_left  = $urandom_range(6, 2);
            seq_first = 1'b1;
        end
        r.scroll_dir = seq_dir;
        if (seq_dir == DIR_UP && seq_first) begin
            r.area_top    = '0;
            r.area_bottom = ROW_W'($urandom_range(lim - 1));
        end else if (seq_dir == DIR_UP && seq_left == 1) begin
            r.area_bottom = ROW_W'(lim - 1);
            r.area_top    = ROW_W'($urandom_range(lim - 1, lo));
        end else if (seq_dir == DIR_DOWN && seq_first) begin
            r.area_bottom = ROW_W'(lim - 1);
            r.area_top    = ROW_W'($urandom_range(lim - 1));
        end else if (seq_dir == DIR_DOWN && seq_left == 1) begin
            r.area_top    = '0;
            r.area_bottom = ROW_W'($urandom_range((lim > 1) ? lim - 2 : 0));
        end else begin
            r.area_top    = ROW_W'($urandom_range(lim - 1, (seq_dir == DIR_NONE) ? 0 : lo));
            r.area_bottom = ROW_W'($urandom_range(lim - 1, r.area_top));
        end
        seq_left--;
        seq_first = 1'b0;
        return r;
    endfunction

    // offer one rectangle, possibly after an idle burst, until accepted
    task automatic send_rect(input t_rect r);
        int unsigned n;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            n = $urandom_range(6, 1);
            repeat (n) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_area_left   <= r.area_left;
        i_area_right  <= r.area_right;
        i_area_top    <= r.area_top;
        i_area_bottom <= r.area_bottom;
        i_scroll_dir  <= r.scroll_dir;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // drop valid and wait until every window is back and the block is quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        // let the monitor log the last accepted rectangle first
        @(posedge i_clk);
        while (sb.pending_windows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input int unsigned val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= ROW_W'(val);
        @(posedge i_clk);
        sb.set_register(idx, ROW_W'(val));
    endtask

    task automatic set_frame(input int unsigned total, input int unsigned visible);
        cfg_write(CFG_TOTAL, total);
        cfg_write(CFG_VISIBLE, visible);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        int unsigned total, visible;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gap_pct = 20;

        // reset frame settings: full screen, extremes, wraps and scrolls
        send_rect(rect(0, 239, 0, 239, DIR_NONE));
        send_rect(rect(255, 255, 511, 511, DIR_NONE));
        send_rect(rect(10, 5, 20, 30, DIR_NONE));
        send_rect(rect(1, 0, 0, 0, DIR_NONE));
        send_rect(rect(0, 255, 0, 511, DIR_NONE));
        send_rect(rect(3, 40, 330, 100, DIR_NONE));
        send_rect(rect(0, 99, 100, 50, DIR_NONE));
        send_rect(rect(0, 239, 0, 39, DIR_UP));
        send_rect(rect(5, 200, 100, 139, DIR_UP));
        send_rect(rect(0, 239, 200, 239, DIR_UP));
        send_rect(rect(7, 77, 50, 120, DIR_NONE));
        send_rect(rect(0, 239, 200, 239, DIR_DOWN));
        send_rect(rect(0, 239, 10, 29, DIR_DOWN));
        send_rect(rect(0, 239, 0, 99, DIR_DOWN));
        send_rect(rect(0, 239, 0, 238, DIR_DOWN));
        send_rect(rect(0, 239, 0, 239, DIR_SPARE));
        settle();

        // zero modulus and no visible rows
        set_frame(0, 0);
        send_rect(rect(0, 239, 0, 511, DIR_DOWN));
        send_rect(rect(0, 239, 0, 0, DIR_UP));
        send_rect(rect(0, 239, 5, 10, DIR_UP));
        send_rect(rect(12, 34, 511, 3, DIR_NONE));
        settle();

        // single row frame, then the largest nonzero total setting
        set_frame(1, 1);
        send_rect(rect(0, 0, 0, 0, DIR_DOWN));
        send_rect(rect(0, 0, 0, 0, DIR_UP));
        send_rect(rect(0, 0, 3, 0, DIR_UP));
        settle();
        set_frame(511, 511);
        send_rect(rect(0, 239, 0, 510, DIR_DOWN));
        send_rect(rect(0, 239, 510, 510, DIR_UP));
        send_rect(rect(0, 239, 0, 509, DIR_DOWN));
        settle();

        // random phases, each under its own frame settings
        for (int p = 0; p < RAND_PHASES; p++) begin
            total   = PHASE_TOTAL[p];
            visible = PHASE_VISIBLE[p];
            if (p == RAND_PHASES - 2) begin
                total   = $urandom_range(511, 1);
                visible = $urandom_range(total, 1);
            end
            set_frame(total, visible);
            gap_pct  = PHASE_GAP[p];
            seq_left = 0;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // long receiver hold-off while rectangles keep coming
                if ((p == 1 || p == 5) && k == HOLD_AT_ITEM) hold_req = 1'b1;
                send_rect(make_rect());
            end
            settle();
        end

        if (sb.errors == 0 && sb.pending_windows.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/sfwm_pkg.sv
sv/scrolling_frame_window_mapper.sv
tb/testbench.sv
